[sv/sthp_pkg.sv]
// Shared constants and helpers for the sphere-to-HEALPix pixel block.
package sthp_pkg;

  // Largest supported resolution exponent.
  localparam int unsigned MaxNsideLog2 = 13;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegNsideLog2 = 2'd0;
  localparam logic [1:0] RegRingOrder = 2'd1;

  // Result bits of the cap square root and number of root stages.
  localparam int unsigned RootW = 31;
  // Width of the square root radicand.
  localparam int unsigned RadW  = 62;
  // Width of the pixel number.
  localparam int unsigned PixW  = 30;

  // Interleave in-face x (even bits) and y (odd bits) into a nested index.
  function automatic logic [25:0] interleave(input logic [12:0] x, input logic [12:0] y);
    logic [25:0] r;
    r = '0;
    for (int b = 0; b < 13; b++) begin
      r[2*b]   = x[b];
      r[2*b+1] = y[b];
    end
    return r;
  endfunction

endpackage

[sv/sphere_to_healpix_pixel.sv]
// Pipelined HEALPix direction-to-pixel unit with ring and nested ordering.
//
// Channel   Dir  Width  Contents
// s_axis    in   64     tdata: cos_colatitude [31:0], longitude_turn [63:32]
// m_axis    out  32     tdata: pixel_index [29:0], zero pad [31:30]
// cfg       in   2+4    cfg_index_i register index, cfg_data_i value
//
// One direction is taken every cycle while the output is not held; the cap
// square root is built from 31 one-bit stages.
// Reset clears all stage valid bits and the registers (nside_log2 = 0, nested).
// When the output is held by m_axis_tready low, the whole pipeline holds, and
// s_axis_tready falls with it; nothing is dropped or repeated.
module sphere_to_healpix_pixel #(
  parameter int unsigned MAX_NSIDE_LOG2 = sthp_pkg::MaxNsideLog2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // cos_colatitude [31:0], longitude_turn [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_index [29:0], zero pad [31:30]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned NRoot = sthp_pkg::RootW;
  localparam int unsigned RadW  = sthp_pkg::RadW;
  localparam int unsigned PixW  = sthp_pkg::PixW;

  // Configuration registers.
  logic [3:0] nside_log2_q;
  logic       ring_order_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nside_log2_q <= '0;
      ring_order_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sthp_pkg::RegNsideLog2) nside_log2_q <= cfg_data_i;
      if (cfg_index_i == sthp_pkg::RegRingOrder) ring_order_q <= cfg_data_i[0];
    end
  end

  // Saturated resolution and nside.
  logic [3:0]  k;
  logic [13:0] n;
  assign k = (nside_log2_q > 4'(MAX_NSIDE_LOG2)) ? 4'(MAX_NSIDE_LOG2) : nside_log2_q;
  assign n = 14'd1 << k;

  // Global advance: the pipeline moves when the output register can take data.
  logic en;
  logic o_vld_q;
  assign en            = !o_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage A: saturate z, belt test.
  logic signed [31:0] z_in, z_sat;
  logic [30:0]        zabs_w;
  logic               a_vld_q, a_belt_q, a_zneg_q;
  logic signed [31:0] a_z_q;
  logic [30:0]        a_zabs_q;
  logic [31:0]        a_phi_q;

  assign z_in = $signed(s_axis_tdata[31:0]);
  always_comb begin
    if (z_in > 32'sd1073741824)       z_sat = 32'sd1073741824;
    else if (z_in < -32'sd1073741824) z_sat = -32'sd1073741824;
    else                              z_sat = z_in;
  end
  assign zabs_w = z_sat[31] ? 31'(-z_sat) : z_sat[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_z_q    <= z_sat;
      a_zabs_q <= zabs_w;
      a_zneg_q <= z_sat[31];
      a_belt_q <= ({2'b0, zabs_w} * 33'd3) <= 33'h80000000;
      a_phi_q  <= s_axis_tdata[63:32];
    end
  end

  // Stage B: belt column indexes and cap radicand.
  logic [34:0]        base_w;
  logic signed [35:0] z3_w, ap_w, am_w;
  logic [5:0]         bsh;
  logic               b_vld_q, b_belt_q, b_zneg_q;
  logic [16:0]        b_jp_q, b_jm_q;
  logic [RadW-1:0]    b_rad_q;
  logic [31:0]        b_phi_q;

  assign base_w = 35'h80000000 + {1'b0, a_phi_q, 2'b00};
  assign z3_w   = 36'(a_z_q) * 36'sd3;
  assign ap_w   = $signed({1'b0, base_w}) - z3_w;
  assign am_w   = $signed({1'b0, base_w}) + z3_w;
  assign bsh    = 6'd32 - {2'b0, k};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_jp_q   <= 17'(ap_w[34:0] >> bsh);
      b_jm_q   <= 17'(am_w[34:0] >> bsh);
      b_rad_q  <= {(32'd3 * {1'b0, 31'h40000000 - a_zabs_q}), 30'b0};
      b_belt_q <= a_belt_q;
      b_zneg_q <= a_zneg_q;
      b_phi_q  <= a_phi_q;
    end
  end

  // Belt pixel, ring and nested forms.
  logic signed [31:0] ns, jps, jms, bir, bv, bhalf, bip, brpix, nn;
  logic [2:0]         ifp, ifm;
  logic [3:0]         bface;
  logic [12:0]        bix, biy;
  logic [31:0]        bnpix;

  assign ns  = {18'b0, n};
  assign jps = {15'b0, b_jp_q};
  assign jms = {15'b0, b_jm_q};
  assign nn  = 32'sd1 <<< (2 * k);

  always_comb begin
    bir   = ns + 32'sd1 + jps - jms;
    bv    = jps + jms - ns + {31'b0, ~bir[0]} + 32'sd1;
    bhalf = bv[31] ? -((-bv) >>> 1) : (bv >>> 1);
    bip   = bhalf + 32'sd1;
    if (bip > (ns <<< 2)) bip = bip - (ns <<< 2);
    brpix = (nn <<< 1) - (ns <<< 1) + ((bir - 32'sd1) <<< (k + 4'd2)) + bip - 32'sd1;
  end

  assign ifp = 3'(b_jp_q >> k);
  assign ifm = 3'(b_jm_q >> k);
  always_comb begin
    priority if (ifp == ifm) bface = {2'b01, ifp[1:0]};
    else if (ifp < ifm)      bface = {2'b00, ifp[1:0]};
    else                     bface = {2'b10, ifm[1:0]};
  end
  assign bix   = b_jm_q[12:0] & 13'(n - 14'd1);
  assign biy   = ~b_jp_q[12:0] & 13'(n - 14'd1);
  assign bnpix = {6'b0, sthp_pkg::interleave(bix, biy)} + ({28'b0, bface} << (2 * k));

  // Root pipeline: stage 0 holds the radicand, stage s+1 settles root bit 30-s.
  logic [NRoot:0]  r_vld_q;
  logic [NRoot:0]  r_belt_q, r_zneg_q;
  logic [31:0]     r_phi_q  [NRoot+1];
  logic [PixW-1:0] r_bpix_q [NRoot+1];
  logic [RadW-1:0] r_rem_q  [NRoot+1];
  logic [NRoot-1:0] r_root_q [NRoot+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r_vld_q[0] <= 1'b0;
    else if (en) r_vld_q[0] <= b_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_belt_q[0] <= b_belt_q;
      r_zneg_q[0] <= b_zneg_q;
      r_phi_q[0]  <= b_phi_q;
      r_bpix_q[0] <= ring_order_q ? brpix[PixW-1:0] : bnpix[PixW-1:0];
      r_rem_q[0]  <= b_rad_q;
      r_root_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < NRoot; s++) begin : g_root
    localparam int unsigned Bit = NRoot - 1 - s;
    logic [63:0] trial;
    logic        take;
    assign trial = ({33'b0, r_root_q[s]} << (Bit + 1)) + (64'd1 << (2 * Bit));
    assign take  = {2'b0, r_rem_q[s]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) r_vld_q[s+1] <= 1'b0;
      else if (en) r_vld_q[s+1] <= r_vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        r_belt_q[s+1] <= r_belt_q[s];
        r_zneg_q[s+1] <= r_zneg_q[s];
        r_phi_q[s+1]  <= r_phi_q[s];
        r_bpix_q[s+1] <= r_bpix_q[s];
        r_rem_q[s+1]  <= take ? RadW'({2'b0, r_rem_q[s]} - trial) : r_rem_q[s];
        r_root_q[s+1] <= take ? (r_root_q[s] | (NRoot'(1) << Bit)) : r_root_q[s];
      end
    end
  end

  // Stage M: cap products of the fraction with the root.
  logic [29:0] tp_w;
  logic        m_vld_q, m_belt_q, m_zneg_q;
  logic [31:0] m_phi_q;
  logic [PixW-1:0] m_bpix_q;
  logic [61:0] m_pp_q, m_pm_q;

  assign tp_w = r_phi_q[NRoot][29:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= r_vld_q[NRoot];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_belt_q <= r_belt_q[NRoot];
      m_zneg_q <= r_zneg_q[NRoot];
      m_phi_q  <= r_phi_q[NRoot];
      m_bpix_q <= r_bpix_q[NRoot];
      m_pp_q   <= {1'b0, tp_w} * {31'b0, r_root_q[NRoot]};
      m_pm_q   <= ({1'b0, 31'h40000000 - {1'b0, tp_w}}) * {31'b0, r_root_q[NRoot]};
    end
  end

  // Stage J: cap column indexes and ring number.
  logic [5:0]  csh;
  logic [14:0] jp_w, jm_w;
  logic        j_vld_q, j_belt_q, j_zneg_q;
  logic [31:0] j_phi_q;
  logic [PixW-1:0] j_bpix_q;
  logic [14:0] j_jp_q, j_jm_q, j_ir_q;

  assign csh  = 6'd60 - {2'b0, k};
  assign jp_w = 15'(m_pp_q >> csh);
  assign jm_w = 15'(m_pm_q >> csh);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_vld_q <= 1'b0;
    else if (en) j_vld_q <= m_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      j_belt_q <= m_belt_q;
      j_zneg_q <= m_zneg_q;
      j_phi_q  <= m_phi_q;
      j_bpix_q <= m_bpix_q;
      j_jp_q   <= jp_w;
      j_jm_q   <= jm_w;
      j_ir_q   <= jp_w + jm_w + 15'd1;
    end
  end

  // Stage P: longitude times ring number and ring number squared.
  logic        p_vld_q, p_belt_q, p_zneg_q;
  logic [1:0]  p_ntt_q;
  logic [PixW-1:0] p_bpix_q;
  logic [14:0] p_jp_q, p_jm_q, p_ir_q;
  logic [46:0] p_pir_q;
  logic [29:0] p_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (en) p_vld_q <= j_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_belt_q <= j_belt_q;
      p_zneg_q <= j_zneg_q;
      p_ntt_q  <= j_phi_q[31:30];
      p_bpix_q <= j_bpix_q;
      p_jp_q   <= j_jp_q;
      p_jm_q   <= j_jm_q;
      p_ir_q   <= j_ir_q;
      p_pir_q  <= {15'b0, j_phi_q} * {32'b0, j_ir_q};
      p_sq_q   <= {15'b0, j_ir_q} * {15'b0, j_ir_q};
    end
  end

  // Cap pixel, then the output register.
  logic [17:0]        cip, cir4;
  logic signed [33:0] crpix, nn12, sq_s, ir_s, ip_s;
  logic [13:0]        nm1;
  logic [14:0]        cjp, cjm;
  logic [12:0]        cix, ciy;
  logic [3:0]         cface;
  logic [31:0]        cnpix;
  logic [PixW-1:0]    pix_d, pix_q;

  assign cir4 = {1'b0, p_ir_q, 2'b00};
  always_comb begin
    cip = {1'b0, p_pir_q[46:30]} + 18'd1;
    if (cip > cir4) cip = cip - cir4;
  end
  assign sq_s = {4'b0, p_sq_q};
  assign ir_s = {19'b0, p_ir_q};
  assign ip_s = {16'b0, cip};
  assign nn12 = (34'sd12) <<< (2 * k);
  assign crpix = p_zneg_q ? (nn12 - ((sq_s + ir_s) <<< 1) + ip_s - 34'sd1)
                          : (((sq_s - ir_s) <<< 1) + ip_s - 34'sd1);

  assign nm1 = n - 14'd1;
  assign cjp = (p_jp_q > {1'b0, nm1}) ? {1'b0, nm1} : p_jp_q;
  assign cjm = (p_jm_q > {1'b0, nm1}) ? {1'b0, nm1} : p_jm_q;
  always_comb begin
    if (!p_zneg_q) begin
      cface = {2'b00, p_ntt_q};
      cix   = 13'(nm1 - cjm[13:0]);
      ciy   = 13'(nm1 - cjp[13:0]);
    end else begin
      cface = {2'b10, p_ntt_q};
      cix   = cjp[12:0];
      ciy   = cjm[12:0];
    end
  end
  assign cnpix = {6'b0, sthp_pkg::interleave(cix, ciy)} + ({28'b0, cface} << (2 * k));

  always_comb begin
    if (p_belt_q)          pix_d = p_bpix_q;
    else if (ring_order_q) pix_d = crpix[PixW-1:0];
    else                   pix_d = cnpix[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (en) o_vld_q <= p_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) pix_q <= pix_d;
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {2'b00, pix_q};

  // A delivered pixel lies below 12 * nside * nside.
  a_pix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({4'b0, pix_q} < (34'd12 << (2 * k))))
    else $error("pixel index beyond 12*nside^2");

  // The wrapped cap column lies in 1 .. 4*ir.
  a_cap_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_vld_q && !p_belt_q) |-> (cip >= 18'd1 && cip <= cir4))
    else $error("cap pixel column out of ring");

  // While the output stalls, the A, root and P stages neither gain nor lose an item.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(r_vld_q) && $stable(p_vld_q) && $stable(a_vld_q)))
    else $error("pipeline moved during stall");

endmodule
